>>> rtl/pmne_pkg.sv
package pmne_pkg;

  // Field widths of the stream items
  localparam int PedalIdxW = 4;
  localparam int OffsetW   = 7;
  localparam int NoteW     = 7;
  localparam int ByteW     = 8;
  localparam int ChanW     = 4;
  localparam int HarmW     = 8;
  localparam int InDataW   = 16;
  localparam int OutDataW  = 8;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 8;

  // MIDI command nibbles and message constants
  localparam logic [3:0]       CmdNoteOn     = 4'h9;
  localparam logic [3:0]       CmdNoteOff    = 4'h8;
  localparam logic [NoteW-1:0] VelOn         = 7'd100;
  localparam logic [NoteW-1:0] VelOff        = 7'd0;
  localparam logic [NoteW-1:0] FifthStep     = 7'd7;
  localparam logic [NoteW-1:0] OctaveStep    = 7'd12;
  localparam int               HarmFifthBit  = 4;
  localparam int               HarmOctaveBit = 7;

  // Depth of the queue between front and back
  localparam int QueueDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_PITCH = 2'd0,
    CFG_HARMONY    = 2'd1,
    CFG_CHANNEL    = 2'd2
  } cfg_idx_e;

  // One pedal edge, fully classified, ready to be serialised
  typedef struct packed {
    logic             send_status;
    logic [ByteW-1:0] status;
    logic [NoteW-1:0] root;
    logic [NoteW-1:0] fifth;
    logic [NoteW-1:0] octave;
    logic [NoteW-1:0] velocity;
    logic             add_fifth;
    logic             add_octave;
  } desc_t;

endpackage

>>> rtl/pmne_front.sv
module pmne_front
  import pmne_pkg::*;
#(
  parameter int NUM_PEDALS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [PedalIdxW-1:0] pedal_index_i,
  input  logic [OffsetW-1:0]   pitch_offset_i,
  input  logic                 level_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output desc_t                desc_o
);

  localparam int PedW = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;
  localparam int ExtW = ((PedW > PedalIdxW) ? PedW : PedalIdxW) + 1;

  logic [NoteW-1:0]      base_pitch_q;
  logic [HarmW-1:0]      harmony_q;
  logic [ChanW-1:0]      channel_q;
  logic [NUM_PEDALS-1:0] levels_q, levels_d;
  logic [ByteW-1:0]      running_q, running_d;

  logic [ExtW-1:0]  idx_ext;
  logic [PedW-1:0]  sel;
  logic             in_range;
  logic             accept;
  logic             is_edge;
  logic [NoteW-1:0] root;
  logic [ByteW-1:0] status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_pitch_q <= '0;
      harmony_q    <= '0;
      channel_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_PITCH: base_pitch_q <= cfg_wdata_i[NoteW-1:0];
        CFG_HARMONY:    harmony_q    <= cfg_wdata_i[HarmW-1:0];
        CFG_CHANNEL:    channel_q    <= cfg_wdata_i[ChanW-1:0];
        default: ;
      endcase
    end
  end

  assign ready_o  = !q_full_i;
  assign accept   = valid_i && !q_full_i;
  assign idx_ext  = ExtW'(pedal_index_i);
  assign in_range = idx_ext < ExtW'(NUM_PEDALS);
  assign sel      = idx_ext[PedW-1:0];
  assign is_edge  = in_range && (levels_q[sel] != level_i);
  assign push_o   = accept && is_edge;

  assign root   = base_pitch_q + pitch_offset_i;
  assign status = {(level_i ? CmdNoteOn : CmdNoteOff), channel_q};

  always_comb begin
    desc_o.send_status = (status != running_q);
    desc_o.status      = status;
    desc_o.root        = root;
    desc_o.fifth       = root + FifthStep;
    desc_o.octave      = root + OctaveStep;
    desc_o.velocity    = level_i ? VelOn : VelOff;
    desc_o.add_fifth   = harmony_q[HarmFifthBit];
    desc_o.add_octave  = harmony_q[HarmOctaveBit];
  end

  always_comb begin
    levels_d  = levels_q;
    running_d = running_q;
    if (push_o) begin
      levels_d[sel] = level_i;
      running_d     = status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= '0;
      running_q <= '0;
    end else begin
      levels_q  <= levels_d;
      running_q <= running_d;
    end
  end

  // A transferred edge leaves the pedal's stored level equal to the sample
  a_level_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (levels_q[$past(sel)] == $past(level_i)))
    else $error("pedal level not updated after edge");

endmodule

>>> rtl/pmne_queue.sv
module pmne_queue
  import pmne_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output desc_t desc_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  desc_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

>>> rtl/pmne_back.sv
module pmne_back
  import pmne_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  desc_t               desc_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [OutDataW-1:0] byte_o,
  output logic                last_o
);

  typedef enum logic [6:0] {
    ST_STATUS = 7'b0000001,
    ST_ROOT   = 7'b0000010,
    ST_VEL1   = 7'b0000100,
    ST_FIFTH  = 7'b0001000,
    ST_VEL2   = 7'b0010000,
    ST_OCTAVE = 7'b0100000,
    ST_VEL3   = 7'b1000000
  } step_e;

  desc_t            cur_q, cur_d;
  step_e            step_q, step_d;
  step_e            step_nxt;
  logic             busy_q, busy_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             adv;
  logic             fin;
  logic [ByteW-1:0] cur_byte;

  assign adv = !out_valid_q || ready_i;

  // Byte for the current step and the step that follows it
  always_comb begin
    cur_byte = '0;
    step_nxt = ST_ROOT;
    fin      = 1'b0;
    case (step_q)
      ST_STATUS: begin
        cur_byte = cur_q.status;
        step_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cur_byte = {1'b0, cur_q.root};
        step_nxt = ST_VEL1;
      end
      ST_VEL1: begin
        cur_byte = {1'b0, cur_q.velocity};
        if (cur_q.add_fifth) begin
          step_nxt = ST_FIFTH;
        end else if (cur_q.add_octave) begin
          step_nxt = ST_OCTAVE;
        end else begin
          fin = 1'b1;
        end
      end
      ST_FIFTH: begin
        cur_byte = {1'b0, cur_q.fifth};
        step_nxt = ST_VEL2;
      end
      ST_VEL2: begin
        cur_byte = {1'b0, cur_q.velocity};
        if (cur_q.add_octave) begin
          step_nxt = ST_OCTAVE;
        end else begin
          fin = 1'b1;
        end
      end
      ST_OCTAVE: begin
        cur_byte = {1'b0, cur_q.octave};
        step_nxt = ST_VEL3;
      end
      ST_VEL3: begin
        cur_byte = {1'b0, cur_q.velocity};
        fin      = 1'b1;
      end
      default: begin
        cur_byte = '0;
        fin      = 1'b1;
      end
    endcase
  end

  // Take the next edge as soon as the current one hands over its last byte
  assign pop_o = !empty_i && (!busy_q || (adv && fin));

  always_comb begin
    cur_d       = cur_q;
    step_d      = step_q;
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = busy_q;
      if (busy_q) begin
        out_byte_d = cur_byte;
        out_last_d = fin;
        step_d     = step_nxt;
        busy_d     = !fin;
      end
    end
    if (pop_o) begin
      cur_d  = desc_i;
      step_d = desc_i.send_status ? ST_STATUS : ST_ROOT;
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_ROOT;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign valid_o = out_valid_q;
  assign byte_o  = out_byte_q;
  assign last_o  = out_last_q;

  a_step_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> $onehot(step_q))
    else $error("sequencer step not one-hot");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !ready_i) |=> (out_valid_q && $stable(out_byte_q)
                                   && $stable(out_last_q)))
    else $error("output register changed under stall");

endmodule

>>> rtl/pedal_midi_note_encoder_top.sv
// Pedal MIDI note encoder.
//
// Input stream (s_axis_*): one sampled pedal level per transfer. Each level
// is compared with the stored level of that pedal; a rising edge sends Note On
// messages (velocity 100), a falling edge Note Off messages (velocity 0), for
// the root note and optionally a fifth and an octave per harmony_mask. The
// status byte is left out while it matches the last one sent (running status).
// Output stream (m_axis_*): one MIDI byte per transfer, tlast on the final
// byte of an edge. Samples without an edge produce nothing.
// Configuration: cfg_we_i writes register cfg_idx_i (0 base pitch, 1 harmony
// mask, 2 channel) from cfg_wdata_i; write only while the block is idle.
// Path: an edge passes the queue, the sequencer and the output register.
// Throughput: one output byte per cycle from the back-end sequencer while
// m_axis_tready_i is high, an edge giving 2 to 7 bytes; a two-entry queue
// lets the front take one sample per cycle until it fills.
// Reset: all pedal levels low, no running status, registers cleared.
// Stall: while m_axis_tready_i is low the output byte is held, the sequencer
// stops, and s_axis_tready_o drops once the queue is full.
module pedal_midi_note_encoder_top
  import pmne_pkg::*;
#(
  parameter int NUM_PEDALS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [3:0] pedal_index, [10:4] pitch_offset, [11] level, [15:12] zero
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [7:0] midi_byte
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  desc_t push_desc;
  desc_t head_desc;
  logic  push;
  logic  pop;
  logic  q_full;
  logic  q_empty;

  // Front: edge detection, note arithmetic, running status
  pmne_front #(
    .NUM_PEDALS(NUM_PEDALS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .pedal_index_i (s_axis_tdata_i[3:0]),
    .pitch_offset_i(s_axis_tdata_i[10:4]),
    .level_i       (s_axis_tdata_i[11]),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .desc_o        (push_desc)
  );

  // Queue of classified edges
  pmne_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (push_desc),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .desc_o (head_desc)
  );

  // Back: byte sequencer with output register
  pmne_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .empty_i(q_empty),
    .desc_i (head_desc),
    .pop_o  (pop),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .byte_o (m_axis_tdata_o),
    .last_o (m_axis_tlast_o)
  );

endmodule

>>> sim/pedal_midi_note_encoder_top_tb.sv
`timescale 1ns / 100ps

module pedal_midi_note_encoder_top_tb;
  import pmne_pkg::*;

  // Watchdog, far above the slowest correct run
  localparam int CycleLimit  = 200000;
  // Cycles allowed after the last expected byte before a register write or the end
  localparam int SettleCycles = 20;
  // Receiver hold-off long enough to fill the internal queue and stall the input
  localparam int HoldCycles  = 400;
  localparam int RandPhases  = 8;
  localparam int PhaseItems  = 50;

  // One MIDI byte as seen on the output stream
  typedef struct packed {
    logic [ByteW-1:0] midi_byte;
    logic             last;
  } midi_out_t;

  // Mirror of the encoder: pedal levels, running status, registers, and the
  // MIDI bytes still owed by the block.
  class midi_scoreboard;
    midi_out_t        exp_bytes[$];
    logic [NoteW-1:0] base_pitch;
    logic [HarmW-1:0] harmony;
    logic [ChanW-1:0] channel;
    logic [15:0]      pedal_lvl;
    logic [ByteW-1:0] running_cmd;
    int               errors;

    function new();
      base_pitch  = '0;
      harmony     = '0;
      channel     = '0;
      pedal_lvl   = '0;
      running_cmd = '0;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    function void write_reg(cfg_idx_e which, logic [CfgDataW-1:0] val);
      case (which)
        CFG_BASE_PITCH: base_pitch = val[NoteW-1:0];
        CFG_HARMONY:    harmony    = val[HarmW-1:0];
        CFG_CHANNEL:    channel    = val[ChanW-1:0];
        default: ;
      endcase
    endfunction

    // Status only when it differs from the last one sent
    function void queue_note(logic [ByteW-1:0] status, logic [NoteW-1:0] note,
                             logic [NoteW-1:0] vel);
      if (status != running_cmd) begin
        running_cmd = status;
        exp_bytes.push_back('{midi_byte: status, last: 1'b0});
      end
      exp_bytes.push_back('{midi_byte: {1'b0, note}, last: 1'b0});
      exp_bytes.push_back('{midi_byte: {1'b0, vel}, last: 1'b0});
    endfunction

    // Accepted sample: edge detection and the bytes it owes.
    // A 4-bit index never exceeds the 16 pedals, so no range check here.
    function void note_sample(logic [PedalIdxW-1:0] idx, logic [OffsetW-1:0] off,
                              logic lvl);
      logic [NoteW-1:0] root;
      logic [ByteW-1:0] status;
      logic [NoteW-1:0] vel;
      if (pedal_lvl[idx] == lvl) return;
      pedal_lvl[idx] = lvl;
      root   = base_pitch + off;   // 7-bit wrap
      status = {(lvl ? CmdNoteOn : CmdNoteOff), channel};
      vel    = lvl ? VelOn : VelOff;
      queue_note(status, root, vel);
      if (harmony[HarmFifthBit])  queue_note(status, root + FifthStep, vel);
      if (harmony[HarmOctaveBit]) queue_note(status, root + OctaveStep, vel);
      exp_bytes[exp_bytes.size()-1].last = 1'b1;
    endfunction

    task check_byte(logic [ByteW-1:0] got_byte, logic got_last);
      midi_out_t want;
      if (exp_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", got_byte));
      end else begin
        want = exp_bytes.pop_front();
        if (got_byte !== want.midi_byte)
          report($sformatf("midi_byte %02h, expected %02h", got_byte, want.midi_byte));
        if (got_last !== want.last)
          report($sformatf("last %0b on byte %02h, expected %0b", got_last, got_byte,
                           want.last));
      end
    endtask

    task check_drained();
      if (exp_bytes.size() != 0)
        report($sformatf("%0d bytes never arrived", exp_bytes.size()));
    endtask
  endclass

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                s_tvalid    = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata     = '0;
  logic                m_tvalid;
  logic                m_tready    = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx     = CFG_BASE_PITCH;
  logic [CfgDataW-1:0] cfg_wdata   = '0;

  midi_scoreboard sb = new();

  // Shared knobs between the stimulus and the receiver, and the watchdog count
  bit no_idle     = 1'b0;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int cycles       = 0;

  pedal_midi_note_encoder_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: checks each output transfer, then picks tready for the next
  // cycle. A hold-off request keeps tready low for a counted stretch while
  // the sender carries on, so the queue fills and s_axis_tready drops.
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (!rst_n) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 13);
    end
  end

  // One sample transfer; random gaps before it unless idling is switched off.
  // tvalid stays high on return so back-to-back transfers need no re-raise.
  task send_sample(logic [PedalIdxW-1:0] idx, logic [OffsetW-1:0] off, logic lvl);
    while (!no_idle && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, lvl, off, idx};
    do @(posedge clk); while (!s_tready);
    sb.note_sample(idx, off, lvl);
  endtask

  // Stop offering, wait for every owed byte, then let the pipe settle.
  task drain();
    s_tvalid <= 1'b0;
    while (sb.exp_bytes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Register write, only ever from idle
  task set_reg(cfg_idx_e which, logic [CfgDataW-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= which;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(which, val);
    cfg_we <= 1'b0;
  endtask

  task set_all(logic [CfgDataW-1:0] base, logic [CfgDataW-1:0] harm,
               logic [CfgDataW-1:0] chan);
    set_reg(CFG_BASE_PITCH, base);
    set_reg(CFG_HARMONY, harm);
    set_reg(CFG_CHANNEL, chan);
  endtask

  initial begin
    logic [PedalIdxW-1:0] idx;
    logic [OffsetW-1:0]   off;
    logic                 lvl;
    logic [CfgDataW-1:0]  base;
    logic [CfgDataW-1:0]  harm;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: plain root notes, extremes of index and offset, repeats
    // with no edge
    set_all(8'd0, 8'h00, 8'd0);
    send_sample(4'd0, 7'd0, 1'b1);
    send_sample(4'd0, 7'd0, 1'b1);      // no edge
    send_sample(4'd0, 7'd0, 1'b0);
    send_sample(4'd15, 7'd127, 1'b1);
    send_sample(4'd15, 7'd127, 1'b0);
    send_sample(4'd9, 7'd64, 1'b0);     // already low

    // Full harmony, top base and channel: note wrap, harmony notes landing
    // on zero, running status across edges of the same kind
    set_all(8'd127, 8'hFF, 8'd15);
    send_sample(4'd1, 7'd1, 1'b1);      // root wraps to 0
    send_sample(4'd2, 7'd122, 1'b1);    // fifth wraps to 0
    send_sample(4'd3, 7'd117, 1'b1);    // octave wraps to 0
    send_sample(4'd1, 7'd1, 1'b0);      // Note Off status
    send_sample(4'd2, 7'd122, 1'b0);
    send_sample(4'd3, 7'd117, 1'b0);

    // Fifth only
    set_all(8'd60, 8'h10, 8'd5);
    send_sample(4'd4, 7'd0, 1'b1);
    send_sample(4'd4, 7'd0, 1'b0);
    send_sample(4'd5, 7'd67, 1'b1);     // root 127, fifth wraps

    // Octave only, then a channel change that forces a fresh status
    set_reg(CFG_HARMONY, 8'h80);
    send_sample(4'd6, 7'd3, 1'b1);
    send_sample(4'd5, 7'd67, 1'b0);
    set_reg(CFG_CHANNEL, 8'd6);
    send_sample(4'd7, 7'd0, 1'b1);
    // Mask bits other than fifth and octave do nothing
    set_reg(CFG_HARMONY, 8'h6F);
    send_sample(4'd6, 7'd3, 1'b0);
    send_sample(4'd7, 7'd0, 1'b0);

    // Random phases, each under its own register setting. Most samples
    // toggle their pedal so that edges dominate; the rest are noise.
    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(3))
        0:       base = 8'd0;
        1:       base = 8'd127;
        default: base = 8'($urandom_range(127));
      endcase
      case ($urandom_range(4))
        0:       harm = 8'h00;
        1:       harm = 8'h10;
        2:       harm = 8'h80;
        3:       harm = 8'h90;
        default: harm = 8'($urandom_range(255));
      endcase
      set_all(base, harm, 8'($urandom_range(15)));
      no_idle = (ph == 2);
      if (ph == 4) rx_hold_req = HoldCycles;
      for (int n = 0; n < PhaseItems; n++) begin
        idx = PedalIdxW'($urandom_range(15));
        off = OffsetW'($urandom_range(127));
        if ($urandom_range(99) < 80) lvl = !sb.pedal_lvl[idx];
        else lvl = 1'($urandom_range(1));
        send_sample(idx, off, lvl);
      end
    end
    no_idle = 1'b0;

    drain();
    sb.check_drained();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pmne_pkg.sv
rtl/pmne_front.sv
rtl/pmne_queue.sv
rtl/pmne_back.sv
rtl/pedal_midi_note_encoder_top.sv
sim/pedal_midi_note_encoder_top_tb.sv
